/* src/rvb_pkg.sv */
// Shared types and constants for the radial vignette brightening block.
// No dependencies; every other file of the block imports this package.
package rvb_pkg;

  // Default coordinate width of the datapath
  localparam int COORD_BITS_DEF = 12;

  // Fixed field and register widths
  localparam int FIELD_COORD_W = 12;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int DIM_REG_W     = 13;
  localparam int FEATHER_W     = 17;
  localparam int ASPECT_W      = 17;
  localparam int DIVISOR_W     = 24;

  // Register reset values and Q1.16 one
  localparam logic [DIM_REG_W-1:0] RESET_WIDTH   = 13'd640;
  localparam logic [DIM_REG_W-1:0] RESET_HEIGHT  = 13'd480;
  localparam logic [FEATHER_W-1:0] RESET_FEATHER = 17'd32768;
  localparam logic [FEATHER_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [7:0]           PIX_MAX       = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_FEATHER_AMOUNT = 2'd2
  } cfg_reg_e;

  // Input word: pixel position and BGR channels
  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_column;
    logic [FIELD_COORD_W-1:0] pixel_row;
    logic [7:0]               in_blue;
    logic [7:0]               in_green;
    logic [7:0]               in_red;
  } in_word_t;

  // Output word: brightened BGR channels
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } out_word_t;

  // Channel values carried down the pipeline
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Status of the derived factors
  typedef struct packed {
    logic busy;      // factors being recomputed
    logic wide;      // width above height: scale the column offset
    logic zero_div;  // range divisor is zero: pass pixels unchanged
  } derive_flags_t;

endpackage

/* src/rvb_cfg.sv */
// Configuration registers and the sequencer that derives the centre, aspect
// scale and range divisor from them. Depends on rvb_pkg.
module rvb_cfg #(
  parameter int COORD_BITS = rvb_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rvb_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rvb_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [COORD_BITS-1:0]                cx,
  output logic [COORD_BITS-1:0]                cy,
  output logic [rvb_pkg::ASPECT_W-1:0]         aspect,
  output logic [rvb_pkg::DIVISOR_W-1:0]        divisor,
  output rvb_pkg::derive_flags_t               flags
);
  import rvb_pkg::*;

  localparam int DIMW  = COORD_BITS + 1;
  localparam int EXTW  = (DIMW > DIM_REG_W) ? DIMW : DIM_REG_W;
  localparam int NUMW  = DIMW + 16;
  localparam int SQW   = 2 * COORD_BITS;
  localparam int MAXW  = SQW + 1;
  localparam int PRODW = MAXW + FEATHER_W;
  localparam logic [EXTW-1:0] LIM = EXTW'(1) << COORD_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_SQ   = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIFF = 7'b0100000,
    S_DIV  = 7'b1000000
  } derive_state_t;

  derive_state_t          state;
  logic [DIM_REG_W-1:0]   image_width;
  logic [DIM_REG_W-1:0]   image_height;
  logic [FEATHER_W-1:0]   feather_amount;

  logic [DIMW-1:0]        w_dim, h_dim;
  logic [FEATHER_W-1:0]   f_sat;
  logic                   wr_hit;

  logic                   wide;
  logic                   zero_div;
  logic [FEATHER_W-1:0]   keep_frac;
  logic [SQW-1:0]         cxx, cyy;
  logic [MAXW-1:0]        maxv;
  logic [PRODW-1:0]       prod;
  logic [MAXW-1:0]        diff_next;
  logic [NUMW-1:0]        rem, dsh;
  logic [ASPECT_W-1:0]    quo;
  logic [4:0]             cnt;
  logic                   ge;

  // Clamp a frame size to 1 .. 2^COORD_BITS
  function automatic logic [DIMW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [EXTW-1:0] e;
    logic [DIMW-1:0] r;
    e = EXTW'(v);
    if (e == '0) begin
      r = DIMW'(1);
    end else if (e > LIM) begin
      r = DIMW'(LIM);
    end else begin
      r = DIMW'(e);
    end
    return r;
  endfunction

  // Clamp the inputs of the derivation
  always_comb begin
    w_dim = clamp_dim(image_width);
    h_dim = clamp_dim(image_height);
    f_sat = (feather_amount > ONE_Q16) ? ONE_Q16 : feather_amount;
  end

  // Decode a write to a known register
  always_comb begin
    unique case (cfg_index)
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_FEATHER_AMOUNT: wr_hit = cfg_valid;
      default: wr_hit = 1'b0;
    endcase
  end

  // One restoring step of the aspect division and the range difference
  always_comb begin
    ge = (rem >= dsh);
    diff_next = maxv - MAXW'(prod >> 16);
  end

  // Hold the registers and run the derivation sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RESET_WIDTH;
      image_height   <= RESET_HEIGHT;
      feather_amount <= RESET_FEATHER;
      state          <= S_LOAD;
    end else if (wr_hit) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width    <= cfg_data[DIM_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height   <= cfg_data[DIM_REG_W-1:0];
        default:          feather_amount <= cfg_data[FEATHER_W-1:0];
      endcase
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_IDLE: state <= S_IDLE;
        S_LOAD: state <= S_SQ;
        S_SQ:   state <= S_SUM;
        S_SUM:  state <= S_MUL;
        S_MUL:  state <= S_DIFF;
        S_DIFF: state <= S_DIV;
        S_DIV:  state <= (cnt == '0) ? S_IDLE : S_DIV;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Derived factor datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        cx        <= w_dim[DIMW-1:1];
        cy        <= h_dim[DIMW-1:1];
        wide      <= (w_dim > h_dim);
        keep_frac <= ONE_Q16 - f_sat;
        rem       <= NUMW'((w_dim > h_dim) ? h_dim : w_dim) << 16;
        dsh       <= NUMW'((w_dim > h_dim) ? w_dim : h_dim) << 16;
        quo       <= '0;
        cnt       <= 5'd16;
      end
      S_SQ: begin
        cxx <= SQW'(cx) * SQW'(cx);
        cyy <= SQW'(cy) * SQW'(cy);
      end
      S_SUM: begin
        maxv <= MAXW'(cxx) + MAXW'(cyy);
      end
      S_MUL: begin
        prod <= PRODW'(maxv) * PRODW'(keep_frac);
      end
      S_DIFF: begin
        divisor  <= DIVISOR_W'(diff_next);
        zero_div <= (DIVISOR_W'(diff_next) == '0);
      end
      S_DIV: begin
        rem <= ge ? (rem - dsh) : rem;
        dsh <= dsh >> 1;
        quo <= {quo[ASPECT_W-2:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          aspect <= {quo[ASPECT_W-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready      = 1'b1;
  assign flags.busy     = (state != S_IDLE);
  assign flags.wide     = wide;
  assign flags.zero_div = zero_div;

endmodule

/* src/rvb_dist.sv */
// Four-stage squared-distance pipeline: offsets, aspect scaling, square, sum.
// Depends on rvb_pkg.
module rvb_dist #(
  parameter int COORD_BITS = rvb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_take,
  input  rvb_pkg::in_word_t             in_word,
  input  logic [COORD_BITS-1:0]         cx,
  input  logic [COORD_BITS-1:0]         cy,
  input  logic [rvb_pkg::ASPECT_W-1:0]  aspect,
  input  rvb_pkg::derive_flags_t        flags,
  output logic                          up_ready,
  input  logic                          down_ready,
  output logic                          dist_valid,
  output logic [2*COORD_BITS+2:0]       dist_sq,
  output rvb_pkg::rgb_t                 dist_rgb
);
  import rvb_pkg::*;

  localparam int PW  = COORD_BITS + ASPECT_W;
  localparam int PPW = 2 * PW;
  localparam int SHW = PPW - 32;
  localparam int BBW = 2 * COORD_BITS;
  localparam int DW  = 2 * COORD_BITS + 3;

  logic [3:0]            v, ld;
  logic [COORD_BITS-1:0] x, y, ax, ay;
  logic [COORD_BITS-1:0] a1, b1;
  logic [PW-1:0]         p2;
  logic [BBW-1:0]        bb2, bb3;
  logic [PPW-1:0]        pp;
  logic [SHW-1:0]        sqh3;
  rgb_t                  rgb1, rgb2, rgb3;

  // Advance a stage when the next one is free or moving
  always_comb begin
    ld[3] = !v[3] || down_ready;
    for (int k = 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  // Offsets from the centre and the square of the scaled offset
  always_comb begin
    x  = COORD_BITS'(in_word.pixel_column);
    y  = COORD_BITS'(in_word.pixel_row);
    ax = (cx > x) ? (cx - x) : (x - cx);
    ay = (cy > y) ? (cy - y) : (y - cy);
    pp = PPW'(p2) * PPW'(p2);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_take;
      for (int k = 1; k < 4; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a1   <= flags.wide ? ax : ay;
      b1   <= flags.wide ? ay : ax;
      rgb1 <= '{blue: in_word.in_blue, green: in_word.in_green, red: in_word.in_red};
    end
    if (ld[1]) begin
      p2   <= PW'(a1) * PW'(aspect);
      bb2  <= BBW'(b1) * BBW'(b1);
      rgb2 <= rgb1;
    end
    if (ld[2]) begin
      sqh3 <= pp[PPW-1:32];
      bb3  <= bb2;
      rgb3 <= rgb2;
    end
    if (ld[3]) begin
      dist_sq  <= DW'(sqh3) + DW'(bb3);
      dist_rgb <= rgb3;
    end
  end

  assign up_ready   = ld[0];
  assign dist_valid = v[3];

endmodule

/* src/rvb_quot.sv */
// Brightening pipeline: d*255, saturation test, eight restoring quotient
// steps against the range divisor, then the saturating channel add. Uses rvb_pkg.
module rvb_quot #(
  parameter int COORD_BITS = rvb_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           dist_valid,
  input  logic [2*COORD_BITS+2:0]        dist_sq,
  input  rvb_pkg::rgb_t                  dist_rgb,
  input  logic [rvb_pkg::DIVISOR_W-1:0]  divisor,
  input  rvb_pkg::derive_flags_t         flags,
  output logic                           up_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rvb_pkg::out_word_t             out_word
);
  import rvb_pkg::*;

  localparam int DW   = 2 * COORD_BITS + 3;
  localparam int NW   = DW + 8;
  localparam int CMPW = (NW > 32) ? NW : 32;
  localparam int NS   = 11;
  localparam int LAST = NS - 1;

  logic [NS-1:0]  v, ld;
  logic [NW-1:0]  n0;
  rgb_t           rgb_s [0:LAST-1];
  logic           sat_s [1:LAST-1];
  logic [31:0]    rem_s [1:LAST-1];
  logic [7:0]     q_s   [1:LAST-1];
  logic [31:0]    dsh   [2:LAST-1];
  logic           ge    [2:LAST-1];

  // Saturating add of the brightening to one channel
  function automatic logic [7:0] brighten(input logic [7:0] c, input logic [7:0] q,
                                          input logic sat);
    logic [8:0] s;
    s = {1'b0, c} + {1'b0, q};
    return (sat || s[8]) ? PIX_MAX : s[7:0];
  endfunction

  // Advance a stage when the next one is free or moving
  always_comb begin
    ld[LAST] = !v[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  // Trial subtrahends, one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 2; k < LAST; k++) begin
      dsh[k] = 32'(divisor) << (LAST - 1 - k);
      ge[k]  = (rem_s[k-1] >= dsh[k]);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= dist_valid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      n0       <= (NW'(dist_sq) << 8) - NW'(dist_sq);
      rgb_s[0] <= dist_rgb;
    end
    // a quotient of 256 or more saturates every channel
    if (ld[1]) begin
      sat_s[1] <= (CMPW'(n0) >= (CMPW'(divisor) << 8));
      rem_s[1] <= 32'(n0);
      q_s[1]   <= '0;
      rgb_s[1] <= rgb_s[0];
    end
    for (int k = 2; k < LAST; k++) begin
      if (ld[k]) begin
        rem_s[k] <= ge[k] ? (rem_s[k-1] - dsh[k]) : rem_s[k-1];
        q_s[k]   <= {q_s[k-1][6:0], ge[k]};
        sat_s[k] <= sat_s[k-1];
        rgb_s[k] <= rgb_s[k-1];
      end
    end
    // zero divisor passes the pixel unchanged
    if (ld[LAST]) begin
      if (flags.zero_div) begin
        out_word.out_blue  <= rgb_s[LAST-1].blue;
        out_word.out_green <= rgb_s[LAST-1].green;
        out_word.out_red   <= rgb_s[LAST-1].red;
      end else begin
        out_word.out_blue  <= brighten(rgb_s[LAST-1].blue,  q_s[LAST-1], sat_s[LAST-1]);
        out_word.out_green <= brighten(rgb_s[LAST-1].green, q_s[LAST-1], sat_s[LAST-1]);
        out_word.out_red   <= brighten(rgb_s[LAST-1].red,   q_s[LAST-1], sat_s[LAST-1]);
      end
    end
  end

  assign up_ready  = ld[0];
  assign out_valid = v[LAST];

endmodule

/* src/radial_vignette_brighten.sv */
// Radial vignette brightening through a 15-stage pipeline with a valid bit
// per stage, so bubbles close up under output stall. Sustains one pixel per
// cycle while the output is not stalled and no factors are being recomputed.
// After reset, and after each register write, the input stalls while the
// sequencer recomputes the centre, range divisor and aspect scale (17-step
// restoring divider). Reset is synchronous and clears control state.
module radial_vignette_brighten #(
  parameter int COORD_BITS = rvb_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rvb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rvb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rvb_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rvb_pkg::out_word_t              out_word
);
  import rvb_pkg::*;

  logic [COORD_BITS-1:0]   cx, cy;
  logic [ASPECT_W-1:0]     aspect;
  logic [DIVISOR_W-1:0]    divisor;
  derive_flags_t           flags;
  logic                    dist_ready, quot_ready, dist_valid, in_take;
  logic [2*COORD_BITS+2:0] dist_sq;
  rgb_t                    dist_rgb;

  // Hold input while factors are recomputed or the pipe is full
  assign in_stall = !dist_ready || flags.busy;
  assign in_take  = in_valid && !in_stall;

  rvb_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cx        (cx),
    .cy        (cy),
    .aspect    (aspect),
    .divisor   (divisor),
    .flags     (flags)
  );

  rvb_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .in_word    (in_word),
    .cx         (cx),
    .cy         (cy),
    .aspect     (aspect),
    .flags      (flags),
    .up_ready   (dist_ready),
    .down_ready (quot_ready),
    .dist_valid (dist_valid),
    .dist_sq    (dist_sq),
    .dist_rgb   (dist_rgb)
  );

  rvb_quot #(.COORD_BITS(COORD_BITS)) u_quot (
    .clk        (clk),
    .rst        (rst),
    .dist_valid (dist_valid),
    .dist_sq    (dist_sq),
    .dist_rgb   (dist_rgb),
    .divisor    (divisor),
    .flags      (flags),
    .up_ready   (quot_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

/* src/rvb_check.sv */
// Port-level checker for radial_vignette_brighten and its bind statement.
// Depends on rvb_pkg and the top-level port names.
module rvb_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [rvb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input rvb_pkg::out_word_t              out_word
);
  import rvb_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  // Reset empties the pipe and starts the factor derivation
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("reset did not empty pipe or stall input");

  // A register write stalls input while factors are recomputed
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
    (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
     cfg_index == CFG_FEATHER_AMOUNT) |=> in_stall)
    else $error("input not stalled after register write");

endmodule

bind radial_vignette_brighten rvb_check u_rvb_check (.*);

/* verif/radial_vignette_brighten_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for radial_vignette_brighten: random and directed pixels
// under many frame settings, checked by an in-bench predictor. Uses rvb_pkg.
module radial_vignette_brighten_test;
  import rvb_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 100;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  // Predict brightened pixels and hold them until the block delivers them
  class vignette_scoreboard;
    logic [DIM_REG_W-1:0] width_reg;
    logic [DIM_REG_W-1:0] height_reg;
    logic [FEATHER_W-1:0] feather_reg;
    bit [63:0] frame_w;
    bit [63:0] frame_h;
    bit [63:0] aspect_q16;
    bit [63:0] divisor;
    out_word_t expected_pixels[$];
    int errors;
    int checked;

    function new();
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      feather_reg = RESET_FEATHER;
      errors = 0;
      checked = 0;
      refresh_factors();
    endfunction

    // Clamp a frame size into 1 .. 2^COORD_BITS
    function bit [63:0] clamp_dim(bit [63:0] v);
      bit [63:0] lim;
      lim = 64'd1 << COORD_BITS;
      if (v == 0) return 64'd1;
      if (v > lim) return lim;
      return v;
    endfunction

    // Rebuild the aspect scale and range divisor from the registers
    function void refresh_factors();
      bit [63:0] f;
      bit [63:0] cx;
      bit [63:0] cy;
      bit [63:0] maxv;
      bit [63:0] minv;
      frame_w = clamp_dim(64'(width_reg));
      frame_h = clamp_dim(64'(height_reg));
      f = (feather_reg > ONE_Q16) ? 64'(ONE_Q16) : 64'(feather_reg);
      cx = frame_w >> 1;
      cy = frame_h >> 1;
      maxv = cx * cx + cy * cy;
      minv = (maxv * (64'd65536 - f)) >> 16;
      divisor = (maxv - minv) & 64'hFF_FFFF;
      if (frame_w > frame_h) aspect_q16 = (frame_h << 16) / frame_w;
      else aspect_q16 = (frame_w << 16) / frame_h;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH: width_reg = data[DIM_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[DIM_REG_W-1:0];
        CFG_FEATHER_AMOUNT: feather_reg = data[FEATHER_W-1:0];
        default: return;
      endcase
      refresh_factors();
    endfunction

    function logic [7:0] saturate(logic [7:0] c, bit [63:0] v);
      bit [63:0] s;
      s = 64'(c) + v;
      return (s > 64'(PIX_MAX)) ? PIX_MAX : s[7:0];
    endfunction

    function out_word_t brightened_pixel(in_word_t px);
      out_word_t res;
      bit [63:0] x;
      bit [63:0] y;
      bit [63:0] cx;
      bit [63:0] cy;
      bit [63:0] ax;
      bit [63:0] ay;
      bit [63:0] k2;
      bit [63:0] d;
      bit [63:0] v;
      x = 64'(px.pixel_column) & ((64'd1 << COORD_BITS) - 1);
      y = 64'(px.pixel_row) & ((64'd1 << COORD_BITS) - 1);
      cx = frame_w >> 1;
      cy = frame_h >> 1;
      ax = (cx > x) ? cx - x : x - cx;
      ay = (cy > y) ? cy - y : y - cy;
      k2 = aspect_q16 * aspect_q16;
      // Zero range: pass the pixel through untouched
      if (divisor == 0) begin
        v = 0;
      end else begin
        if (frame_w > frame_h) d = ((ax * ax * k2) >> 32) + ay * ay;
        else d = ((ay * ay * k2) >> 32) + ax * ax;
        v = (d * 255) / divisor;
      end
      res.out_blue = saturate(px.in_blue, v);
      res.out_green = saturate(px.in_green, v);
      res.out_red = saturate(px.in_red, v);
      return res;
    endfunction

    function void note_pixel(in_word_t px);
      expected_pixels.push_back(brightened_pixel(px));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_pixel(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected output word %h", got));
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.out_blue !== want.out_blue)
        report($sformatf("word %0d blue got %0d want %0d", checked, got.out_blue, want.out_blue));
      if (got.out_green !== want.out_green)
        report($sformatf("word %0d green got %0d want %0d", checked, got.out_green,
                         want.out_green));
      if (got.out_red !== want.out_red)
        report($sformatf("word %0d red got %0d want %0d", checked, got.out_red, want.out_red));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  vignette_scoreboard pixel_board = new();
  int cycle_count = 0;
  int stall_phase = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_run = 1;

  radial_vignette_brighten i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               pixel_board.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check delivered words and drive the output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) pixel_board.check_pixel(out_word);
      stall_phase <= stall_phase + 1;
      if (stall_phase % 256 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase % 7 < 3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_pixel(input in_word_t px);
    in_valid <= 1'b1;
    in_word <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixel_board.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic hold_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_board.pending() != 0) @(posedge clk);
  endtask

  // Advance the burst: keep sending, or open a gap, or drain entirely
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 20);
      hold_input($urandom_range(1, 12));
    end
    if ($urandom_range(0, 299) == 0) wait_for_results();
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pixel_board.set_register(idx, data);
  endtask

  // Write a full frame setting once the pipeline is empty
  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] f, input bit poke_unused);
    wait_for_results();
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    if (poke_unused) write_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
    write_register(CFG_FEATHER_AMOUNT, f);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic in_word_t make_pixel(int col, int row, int b, int g, int r);
    in_word_t px;
    px.pixel_column = col[FIELD_COORD_W-1:0];
    px.pixel_row = row[FIELD_COORD_W-1:0];
    px.in_blue = b[7:0];
    px.in_green = g[7:0];
    px.in_red = r[7:0];
    return px;
  endfunction

  // Mostly pixels inside the frame, some anywhere in coordinate space
  function automatic in_word_t random_pixel();
    in_word_t px;
    int col;
    int row;
    int lo;
    col = $urandom_range(0, int'(pixel_board.frame_w) - 1);
    row = $urandom_range(0, int'(pixel_board.frame_h) - 1);
    if ($urandom_range(0, 4) == 0) col = $urandom_range(0, 4095);
    if ($urandom_range(0, 4) == 0) row = $urandom_range(0, 4095);
    lo = ($urandom_range(0, 3) == 0) ? 230 : 0;
    px = make_pixel(col, row, $urandom_range(lo, 255), $urandom_range(lo, 255),
                    $urandom_range(lo, 255));
    return px;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    case ($urandom_range(0, 3))
      0: return CFG_DATA_W'($urandom_range(1, 64));
      1: return CFG_DATA_W'($urandom_range(1, 4096));
      2: return CFG_DATA_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return CFG_DATA_W'(0);
          1: return CFG_DATA_W'(1);
          2: return CFG_DATA_W'(4096);
          default: return CFG_DATA_W'(8191);
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_feather();
    if ($urandom_range(0, 4) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 65536));
  endfunction

  task automatic run_random(input int n);
    repeat (n) begin
      send_pixel(random_pixel());
      pace_sender();
    end
  endtask

  // Send three frame corners and the far corner of coordinate space with the given channel level
  task automatic send_corners(input int level);
    send_pixel(make_pixel(0, 0, level, level, level));
    send_pixel(make_pixel(int'(pixel_board.frame_w) - 1, 0, level, level, level));
    send_pixel(make_pixel(0, int'(pixel_board.frame_h) - 1, level, level, level));
    send_pixel(make_pixel(4095, 4095, level, level, level));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset frame setting
    send_pixel(make_pixel(320, 240, 0, 0, 0));
    send_pixel(make_pixel(320, 240, 255, 255, 255));
    send_pixel(make_pixel(321, 240, 0, 0, 0));
    send_pixel(make_pixel(320, 241, 0, 0, 0));
    send_pixel(make_pixel(639, 479, 0, 0, 0));
    send_pixel(make_pixel(639, 0, 10, 20, 30));
    send_pixel(make_pixel(0, 479, 200, 100, 50));
    send_corners(0);
    send_pixel(make_pixel(4095, 0, 0, 0, 0));
    send_pixel(make_pixel(0, 4095, 255, 0, 128));
    send_pixel(make_pixel(100, 100, 255, 0, 128));
    hold_input(3);
    send_pixel(make_pixel(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hAA));
    send_pixel(make_pixel(12'h555, 12'hAAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(make_pixel(160, 120, 250, 251, 252));
    run_random(PHASE_ITEMS);

    // Edge settings: square, tiny, oversized, clamped and zero-range frames
    configure(4096, 4096, 65536, 1'b0);
    send_corners(255);
    run_random(PHASE_ITEMS);
    configure(16, 9, 65536, 1'b0);
    run_random(PHASE_ITEMS);
    configure(9, 16, 20000, 1'b1);
    run_random(PHASE_ITEMS);
    configure(1, 1, 65536, 1'b0);
    send_corners(77);
    run_random(PHASE_ITEMS);
    configure(0, 17'h1FFFF, 17'h1FFFF, 1'b0);
    run_random(PHASE_ITEMS);
    configure(640, 480, 0, 1'b0);
    send_corners(200);
    run_random(PHASE_ITEMS);
    configure(2, 1, 1, 1'b0);
    run_random(PHASE_ITEMS);
    configure(4097, 100, 65535, 1'b0);
    run_random(PHASE_ITEMS);

    // Random frame settings
    repeat (6) begin
      configure(random_dim(), random_dim(), random_feather(), 1'b0);
      run_random(PHASE_ITEMS);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_board.pending() != 0)
      pixel_board.report($sformatf("%0d words never arrived", pixel_board.pending()));

    $display("Covered %0d pixels over %0d frame settings, %0d output words compared.",
             pixels_sent, settings_run, pixel_board.checked);
    if (pixel_board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", pixel_board.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* radial_vignette_brighten.f */
src/rvb_pkg.sv
src/rvb_cfg.sv
src/rvb_dist.sv
src/rvb_quot.sv
src/radial_vignette_brighten.sv
src/rvb_check.sv
verif/radial_vignette_brighten_test.sv
